@@ src/xwm_pkg.sv @@
// Shared constants, types and the arctangent table of the x-drive wheel mixer.
package xwm_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int CORDIC_STEPS   = 24;

  localparam int DEMAND_W  = 15;
  localparam int HEADING_W = 16;
  localparam int LIMIT_W   = 15;
  localparam int VOLT_W    = 16;

  localparam int CW     = 34;                  // CORDIC x/y, Q2.30 with headroom
  localparam int ZW     = 32;                  // residual angle, 2^-32 turn units
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;  // covers +-1.0
  localparam int PROD_W = TRIG_W + DEMAND_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MAG_W  = SUM_W - TRIG_FRAC_BITS;
  localparam int QUOT_W = VOLT_W;
  localparam int DIV_W  = SUM_W + LIMIT_W + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(12000);

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [MAG_W-1:0] mag_t;

  // wheel order: front left, front right, back right, back left
  typedef struct packed {
    sum_t [3:0] sum;
    mag_t       peak;
  } mix_rec_t;

  function automatic logic [ZW-1:0] atan_turn(input int i);
    logic [ZW-1:0] a;
    case (i)
      0:       a = 32'h20000000;
      1:       a = 32'h12E4051E;
      2:       a = 32'h09FB385B;
      3:       a = 32'h051111D4;
      4:       a = 32'h028B0D43;
      5:       a = 32'h0145D7E1;
      6:       a = 32'h00A2F61E;
      7:       a = 32'h00517C55;
      8:       a = 32'h0028BE53;
      9:       a = 32'h00145F2F;
      10:      a = 32'h000A2F98;
      11:      a = 32'h000517CC;
      12:      a = 32'h00028BE6;
      13:      a = 32'h000145F3;
      14:      a = 32'h0000A2FA;
      15:      a = 32'h0000517D;
      16:      a = 32'h000028BE;
      17:      a = 32'h0000145F;
      18:      a = 32'h00000A30;
      19:      a = 32'h00000518;
      20:      a = 32'h0000028C;
      21:      a = 32'h00000146;
      22:      a = 32'h000000A3;
      23:      a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ src/xwm_if.sv @@
// Valid/ready channel interfaces for drive commands and wheel voltages.
interface xwm_cmd_if import xwm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [DEMAND_W-1:0] forward_demand;
  logic signed [DEMAND_W-1:0] sideways_demand;
  logic signed [DEMAND_W-1:0] turn_demand;
  logic [HEADING_W-1:0]       heading;

  modport source (output valid, forward_demand, sideways_demand, turn_demand, heading,
                  input ready);
  modport sink (input valid, forward_demand, sideways_demand, turn_demand, heading,
                output ready);
endinterface

interface xwm_volt_if import xwm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VOLT_W-1:0] front_left_voltage;
  logic signed [VOLT_W-1:0] front_right_voltage;
  logic signed [VOLT_W-1:0] back_right_voltage;
  logic signed [VOLT_W-1:0] back_left_voltage;

  modport source (output valid, front_left_voltage, front_right_voltage,
                  back_right_voltage, back_left_voltage, input ready);
  modport sink (input valid, front_left_voltage, front_right_voltage,
                back_right_voltage, back_left_voltage, output ready);
endinterface

@@ src/xwm_front.sv @@
// Front pipeline: CORDIC sine/cosine, heading rotation, wheel mix and peak magnitude.
module xwm_front import xwm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  xwm_cmd_if.sink        cmd,
  output logic           rec_valid,
  input  logic           rec_ready,
  output mix_rec_t       rec
);

  logic en;

  logic signed [CW-1:0]       cx  [0:CORDIC_STEPS];
  logic signed [CW-1:0]       cy  [0:CORDIC_STEPS];
  logic signed [ZW-1:0]       cz  [0:CORDIC_STEPS];
  logic [1:0]                 cq  [0:CORDIC_STEPS];
  logic signed [DEMAND_W-1:0] pvx [0:CORDIC_STEPS];
  logic signed [DEMAND_W-1:0] pvy [0:CORDIC_STEPS];
  logic signed [DEMAND_W-1:0] pw  [0:CORDIC_STEPS];
  logic [CORDIC_STEPS:0]      cv;

  logic [ZW-1:0] phase;

  logic signed [TRIG_W-1:0]   c_t, s_t;
  logic signed [DEMAND_W-1:0] vx_t, vy_t, w_t;
  logic                       v_t;
  logic signed [PROD_W-1:0]   p_cvx, p_svy, p_cvy, p_svx;
  logic signed [DEMAND_W-1:0] w_p;
  logic                       v_p;
  logic signed [SUM_W-1:0]    rx_r, ry_r, ws_r;
  logic                       v_r;
  sum_t                       sum_s [4];
  logic                       v_s;
  logic                       v_m;

  logic signed [TRIG_W-1:0] cq_trig, sq_trig, c_map, s_map;
  mag_t mag [4];
  mag_t peak;

  function automatic logic signed [TRIG_W-1:0] to_trig(input logic signed [CW-1:0] q);
    logic signed [CW-1:0] r;
    logic signed [CW-1:0] one;
    one = CW'(1) <<< TRIG_FRAC_BITS;
    r = (q + (CW'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return TRIG_W'(r);
  endfunction

  assign en        = !v_m || rec_ready;
  assign cmd.ready = en;
  assign rec_valid = v_m;

  assign phase = ZW'(cmd.heading[ANGLE_BITS-1:0]) << (ZW - ANGLE_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]  <= CORDIC_GAIN;
      cy[0]  <= '0;
      cz[0]  <= {2'b00, phase[ZW-3:0]};
      cq[0]  <= phase[ZW-1:ZW-2];
      pvx[0] <= cmd.forward_demand;
      pvy[0] <= cmd.sideways_demand;
      pw[0]  <= cmd.turn_demand;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - $signed(atan_turn(i));
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + $signed(atan_turn(i));
        end
        cq[i+1]  <= cq[i];
        pvx[i+1] <= pvx[i];
        pvy[i+1] <= pvy[i];
        pw[i+1]  <= pw[i];
      end
    end
  end

  // quadrant fold back to the full circle
  always_comb begin
    cq_trig = to_trig(cx[CORDIC_STEPS]);
    sq_trig = to_trig(cy[CORDIC_STEPS]);
    case (cq[CORDIC_STEPS])
      2'd0:    begin c_map = cq_trig;  s_map = sq_trig;  end
      2'd1:    begin c_map = -sq_trig; s_map = cq_trig;  end
      2'd2:    begin c_map = -cq_trig; s_map = -sq_trig; end
      default: begin c_map = sq_trig;  s_map = -cq_trig; end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag[k] = MAG_W'((sum_s[k] < 0 ? -sum_s[k] : sum_s[k]) >> TRIG_FRAC_BITS);
    end
    peak = mag[0];
    for (int k = 1; k < 4; k++) begin
      if (mag[k] > peak) peak = mag[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_t   <= c_map;
      s_t   <= s_map;
      vx_t  <= pvx[CORDIC_STEPS];
      vy_t  <= pvy[CORDIC_STEPS];
      w_t   <= pw[CORDIC_STEPS];
      p_cvx <= c_t * vx_t;
      p_svy <= s_t * vy_t;
      p_cvy <= c_t * vy_t;
      p_svx <= s_t * vx_t;
      w_p   <= w_t;
      rx_r  <= SUM_W'(p_cvx) + SUM_W'(p_svy);
      ry_r  <= SUM_W'(p_cvy) - SUM_W'(p_svx);
      ws_r  <= SUM_W'(w_p) <<< TRIG_FRAC_BITS;
      sum_s[0] <= rx_r + ry_r + ws_r;
      sum_s[1] <= ry_r - rx_r - ws_r;
      sum_s[2] <= rx_r + ry_r - ws_r;
      sum_s[3] <= ry_r - rx_r + ws_r;
      for (int k = 0; k < 4; k++) rec.sum[k] <= sum_s[k];
      rec.peak <= peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv  <= '0;
      v_t <= 1'b0;
      v_p <= 1'b0;
      v_r <= 1'b0;
      v_s <= 1'b0;
      v_m <= 1'b0;
    end else if (en) begin
      cv  <= {cv[CORDIC_STEPS-1:0], cmd.valid};
      v_t <= cv[CORDIC_STEPS];
      v_p <= v_t;
      v_r <= v_p;
      v_s <= v_r;
      v_m <= v_s;
    end
  end

endmodule

@@ src/xwm_fifo.sv @@
// Short queue of mixed wheel sums between the front and back pipelines.
module xwm_fifo import xwm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  mix_rec_t push_data,
  input  logic     pop,
  output mix_rec_t pop_data,
  output logic     full,
  output logic     empty
);

  mix_rec_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0]   count;

  assign full     = count == FIFO_CW'(FIFO_DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/xwm_back.sv @@
// Back pipeline: desaturation scaling by a bit-per-stage divider, sign restore.
module xwm_back import xwm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] limit,
  input  logic               rec_valid,
  output logic               rec_ready,
  input  mix_rec_t           rec,
  xwm_volt_if.source         volt
);

  logic en;
  logic ov;

  logic [DIV_W-1:0]  rem  [0:QUOT_W-1][4];
  logic [QUOT_W-1:0] quo  [1:QUOT_W][4];
  logic [DIV_W-1:0]  den  [0:QUOT_W-1];
  logic [3:0]        sg   [0:QUOT_W];
  logic [QUOT_W:0]   dv;

  logic             scale;
  logic [SUM_W-1:0] mag_in [4];

  assign en        = !ov || volt.ready;
  assign rec_ready = en;
  assign volt.valid = ov;

  assign scale = rec.peak > MAG_W'(limit);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag_in[k] = rec.sum[k][SUM_W-1] ? SUM_W'(-rec.sum[k]) : SUM_W'(rec.sum[k]);
    end
  end

  // dividend |sum|*limit over peak*2^F when scaling, else |sum| over 2^F
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        rem[0][k] <= scale ? DIV_W'(mag_in[k]) * DIV_W'(limit) : DIV_W'(mag_in[k]);
        sg[0][k]  <= rec.sum[k][SUM_W-1];
      end
      den[0] <= scale ? DIV_W'(rec.peak) << TRIG_FRAC_BITS : DIV_W'(1) << TRIG_FRAC_BITS;
    end
  end

  for (genvar j = 1; j <= QUOT_W; j++) begin : g_div
    localparam int BIT = QUOT_W - j;
    logic [DIV_W-1:0] trial;
    assign trial = den[j-1] << BIT;
    for (genvar k = 0; k < 4; k++) begin : g_lane
      logic              take;
      logic [QUOT_W-1:0] q_prev;
      assign take = rem[j-1][k] >= trial;
      if (j == 1) begin : g_first
        assign q_prev = '0;
      end else begin : g_next
        assign q_prev = quo[j-1][k];
      end
      always_ff @(posedge clk) begin
        if (en) quo[j][k] <= q_prev | (QUOT_W'(take) << BIT);
      end
      if (j < QUOT_W) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) rem[j][k] <= take ? rem[j-1][k] - trial : rem[j-1][k];
        end
      end
    end
    if (j < QUOT_W) begin : g_den
      always_ff @(posedge clk) begin
        if (en) den[j] <= den[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) sg[j] <= sg[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      volt.front_left_voltage  <= sg[QUOT_W][0] ? -quo[QUOT_W][0] : quo[QUOT_W][0];
      volt.front_right_voltage <= sg[QUOT_W][1] ? -quo[QUOT_W][1] : quo[QUOT_W][1];
      volt.back_right_voltage  <= sg[QUOT_W][2] ? -quo[QUOT_W][2] : quo[QUOT_W][2];
      volt.back_left_voltage   <= sg[QUOT_W][3] ? -quo[QUOT_W][3] : quo[QUOT_W][3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
      ov <= 1'b0;
    end else if (en) begin
      dv <= {dv[QUOT_W-1:0], rec_valid};
      ov <= dv[QUOT_W];
    end
  end

endmodule

@@ src/xdrive_wheel_mixer_top.sv @@
// Top level of the x-drive wheel mixer: limit register, front, queue and back.
// Throughput: one command per cycle when nothing stalls;
// the 24-stage CORDIC and 16-stage divider are pipelined.
// The front and back stall independently; a four-entry queue sits between them.
// Reset (rst, synchronous) empties all stages and the queue and sets the limit to 12000.
module xdrive_wheel_mixer_top import xwm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  xwm_cmd_if.sink            cmd,
  xwm_volt_if.source         volt
);

  logic [LIMIT_W-1:0] voltage_limit;

  logic     front_valid;
  logic     front_ready;
  mix_rec_t front_rec;
  logic     back_ready;
  mix_rec_t back_rec;
  logic     q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      voltage_limit <= cfg_wdata;
    end
  end

  assign front_ready = !q_full;
  assign q_push      = front_valid && front_ready;
  assign q_pop       = !q_empty && back_ready;

  xwm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rec_valid (front_valid),
    .rec_ready (front_ready),
    .rec       (front_rec)
  );

  xwm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_rec),
    .pop       (q_pop),
    .pop_data  (back_rec),
    .full      (q_full),
    .empty     (q_empty)
  );

  xwm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .limit     (voltage_limit),
    .rec_valid (!q_empty),
    .rec_ready (back_ready),
    .rec       (back_rec),
    .volt      (volt)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(q_pop && q_empty))
    else $error("queue read while empty");
  a_reset_idle: assert property (@(posedge clk) rst |=> !volt.valid)
    else $error("result valid right after reset");
  a_queue_flag: assert property (@(posedge clk) disable iff (rst) !(q_full && q_empty))
    else $error("queue full and empty at once");
`endif

endmodule

@@ verif/xwm_tb_if.sv @@
// Record types for drive commands and expected wheel voltages in the testbench.
`timescale 1ns / 100ps
package xwm_tb_types;
  import xwm_pkg::*;
  typedef struct packed {
    logic signed [DEMAND_W-1:0] fwd;
    logic signed [DEMAND_W-1:0] side;
    logic signed [DEMAND_W-1:0] turn;
    logic [HEADING_W-1:0]       hdg;
  } drive_cmd_t;
  typedef struct packed {
    logic signed [VOLT_W-1:0] fl;
    logic signed [VOLT_W-1:0] fr;
    logic signed [VOLT_W-1:0] br;
    logic signed [VOLT_W-1:0] bl;
  } wheel_volts_t;
endpackage

@@ verif/tb_xdrive_wheel_mixer_top.sv @@
// Self-checking testbench of the x-drive wheel mixer: random and directed commands.
`timescale 1ns / 100ps
module tb_xdrive_wheel_mixer_top;
  import xwm_pkg::*;
  import xwm_tb_types::*;

  localparam int PIPE_LAT  = 48;
  localparam int MAX_CYCLE = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  xwm_cmd_if  cmd ();
  xwm_volt_if volt ();

  xdrive_wheel_mixer_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .cmd(cmd), .volt(volt)
  );

  always #5 clk = ~clk;

  drive_cmd_t   pending_cmds[$];
  wheel_volts_t expected_volts[$];
  longint unsigned limit_mv = 12000;
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;      // no idling in the final stretch
  int  hold_off = 0;     // long receiver hold-off, counted down by the ready process
  int  send_gap = 0;
  int  recv_gap = 0;
  logic in_fire = 1'b0;  // command transfer seen at the last rising edge

  // floor shift of a signed 64-bit value
  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint trig_round(longint q30);
    longint one, r;
    one = longint'(1) << TRIG_FRAC_BITS;
    r = fshift(q30 + (longint'(1) << (29 - TRIG_FRAC_BITS)), 30 - TRIG_FRAC_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r;
  endfunction

  function automatic wheel_volts_t mix_volts(drive_cmd_t c);
    longint unsigned ang, phase, mx, mag;
    int quad;
    longint z, x, y, dx, dy, cq, sq, co, si, vx, vy, w, rx, ry, ws, v, den;
    longint sums[4];
    logic signed [VOLT_W-1:0] o[4];
    wheel_volts_t r;
    ang = c.hdg & ((64'd1 << ANGLE_BITS) - 1);
    phase = (ang << (32 - ANGLE_BITS)) & 64'hFFFF_FFFF;
    quad = int'(phase >> 30);
    z = longint'(phase & 64'h3FFF_FFFF);
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i));
      end
    end
    cq = trig_round(x);
    sq = trig_round(y);
    case (quad)
      0: begin co = cq;  si = sq;  end
      1: begin co = -sq; si = cq;  end
      2: begin co = -cq; si = -sq; end
      default: begin co = sq; si = -cq; end
    endcase
    vx = c.fwd; vy = c.side; w = c.turn;
    rx = co * vx + si * vy;
    ry = -si * vx + co * vy;
    ws = w <<< TRIG_FRAC_BITS;
    sums[0] = rx + ry + ws;
    sums[1] = -rx + ry - ws;
    sums[2] = rx + ry - ws;
    sums[3] = -rx + ry + ws;
    mx = 0;
    for (int k = 0; k < 4; k++) begin
      mag = longint'(sums[k] < 0 ? -sums[k] : sums[k]) >> TRIG_FRAC_BITS;
      if (mag > mx) mx = mag;
    end
    for (int k = 0; k < 4; k++) begin
      if (mx > limit_mv) begin
        den = longint'(mx) <<< TRIG_FRAC_BITS;
        v = (sums[k] * longint'(limit_mv)) / den;
      end else begin
        v = sums[k] / (longint'(1) <<< TRIG_FRAC_BITS);
      end
      o[k] = v[VOLT_W-1:0];
    end
    r.fl = o[0]; r.fr = o[1]; r.br = o[2]; r.bl = o[3];
    return r;
  endfunction

  function automatic logic signed [DEMAND_W-1:0] rand_demand();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return DEMAND_W'($urandom);          // full 15-bit range
    if (sel == 1) return ($urandom_range(0, 1) != 0) ? 15'sd12000 : -15'sd12000;
    return DEMAND_W'(int'($urandom_range(0, 24000)) - 12000);
  endfunction

  function automatic drive_cmd_t rand_cmd();
    drive_cmd_t c;
    c.fwd = rand_demand();
    c.side = rand_demand();
    c.turn = rand_demand();
    c.hdg = ($urandom_range(0, 7) == 0) ? HEADING_W'($urandom_range(0, 3) * 16384)
                                         : HEADING_W'($urandom);
    return c;
  endfunction

  function automatic drive_cmd_t make_cmd(int f, int s, int t, int h);
    drive_cmd_t c;
    c.fwd = DEMAND_W'(f); c.side = DEMAND_W'(s); c.turn = DEMAND_W'(t);
    c.hdg = HEADING_W'(h);
    return c;
  endfunction

  // command transfers are taken at the rising edge, where they happen
  always @(posedge clk) begin
    in_fire <= !rst && cmd.valid && cmd.ready;
  end

  // driver: offers pending commands, predicting at each transfer
  always @(negedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      if (in_fire) begin
        expected_volts.push_back(mix_volts(pending_cmds.pop_front()));
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        cmd.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        if (!calm && (!cmd.valid || in_fire) && $urandom_range(0, 15) == 0) begin
          send_gap <= $urandom_range(1, 12);
          cmd.valid <= 1'b0;
        end else begin
          cmd.valid <= 1'b1;
          {cmd.forward_demand, cmd.sideways_demand, cmd.turn_demand, cmd.heading}
            <= pending_cmds[0];
        end
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // ready: stalls in bursts, plus a long hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      volt.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      volt.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      volt.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      recv_gap <= $urandom_range(1, 12);
      volt.ready <= 1'b0;
    end else begin
      volt.ready <= 1'b1;
    end
  end

  // monitor: checks each transfer of wheel voltages at the rising edge
  always @(posedge clk) begin
    wheel_volts_t exp_v;
    cycle_count <= cycle_count + 1;
    if (!rst && volt.valid && volt.ready) begin
      if (expected_volts.size() == 0) begin
        $error("unexpected voltage transfer");
        fail_count++;
      end else begin
        exp_v = expected_volts.pop_front();
        if (volt.front_left_voltage !== exp_v.fl) begin
          $error("front_left_voltage exp %0d got %0d", exp_v.fl, volt.front_left_voltage);
          fail_count++;
        end
        if (volt.front_right_voltage !== exp_v.fr) begin
          $error("front_right_voltage exp %0d got %0d", exp_v.fr, volt.front_right_voltage);
          fail_count++;
        end
        if (volt.back_right_voltage !== exp_v.br) begin
          $error("back_right_voltage exp %0d got %0d", exp_v.br, volt.back_right_voltage);
          fail_count++;
        end
        if (volt.back_left_voltage !== exp_v.bl) begin
          $error("back_left_voltage exp %0d got %0d", exp_v.bl, volt.back_left_voltage);
          fail_count++;
        end
      end
    end
    if (cycle_count > MAX_CYCLE) begin
      $display("tb: failure");
      $finish;
    end
  end

  // waits until every command has gone through and its result has been checked
  task automatic drain();
    while (pending_cmds.size() > 0 || cmd.valid || expected_volts.size() > 0)
      @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic set_limit(int unsigned lim);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= LIMIT_W'(lim);
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_mv = lim;
  endtask

  initial begin
    int unsigned limits[6] = '{12000, 1, 32767, 0, 5000, 20000};
    cmd.valid = 1'b0;
    cmd.forward_demand = '0; cmd.sideways_demand = '0;
    cmd.turn_demand = '0; cmd.heading = '0;
    volt.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, headings on each quadrant, all-zero
    pending_cmds.push_back(make_cmd(0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(12000, 0, 0, 0));
    pending_cmds.push_back(make_cmd(0, 12000, 0, 0));
    pending_cmds.push_back(make_cmd(0, 0, 12000, 0));
    pending_cmds.push_back(make_cmd(-12000, -12000, -12000, 0));
    pending_cmds.push_back(make_cmd(12000, 12000, 12000, 0));
    pending_cmds.push_back(make_cmd(12000, -12000, 12000, 16384));
    pending_cmds.push_back(make_cmd(12000, 5000, -3000, 32768));
    pending_cmds.push_back(make_cmd(-7000, 12000, 100, 49152));
    pending_cmds.push_back(make_cmd(16383, 16383, 16383, 8192));
    pending_cmds.push_back(make_cmd(-16384, -16384, -16384, 65535));
    pending_cmds.push_back(make_cmd(-16384, 16383, -16384, 24576));
    pending_cmds.push_back(make_cmd(1, -1, 1, 1));
    pending_cmds.push_back(make_cmd(6000, 6000, 0, 40960));
    pending_cmds.push_back(make_cmd(-1, 0, 0, 32767));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_limit(limits[ph]);
      if (ph == 2) begin
        // receiver holds off while commands keep coming, filling the pipe
        hold_off = 300;
      end
      if (ph == 5) calm = 1'b1;
      for (int n = 0; n < 100; n++) pending_cmds.push_back(rand_cmd());
      drain();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
